// File: src/slim_pkg.sv
// Shared types and constants for the sorted lists insert and merge block.
// Used by the top level only; no other dependencies.
package slim_pkg;

	// Operation codes carried by an input beat.
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_MERGE  = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_MRG_SEL,
		ST_MRG_LD,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	localparam logic [3:0] LISTS_IN_USE_RESET = 4'd8;

endpackage

// File: src/sorted_lists_insert_merge.sv
// Keeps NUM_LISTS ascending lists in one memory and runs a small sequencer over it. An insert
// walks its list from the tail, reading each element and shifting it up while it is not below
// the value; a full list or bad index answers at once. A merge reads each element of lists 1 to
// lists_in_use-1 (below NUM_LISTS) and inserts it into list 0 the same way, flagging overflow
// instead when list 0 is full, then emits list 0. Each result beat of an emit goes through a
// read state and a load state over the single memory port pair, and waits while output stalls.
// The block takes a new input beat only when it is idle and its output register is empty.
// Depends on slim_pkg and slim_mem.
module sorted_lists_insert_merge #(
	parameter int NUM_LISTS     = 8,
	parameter int LIST_CAPACITY = 32,
	parameter int VALUE_WIDTH   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    operation,
	input  logic [2:0]                    list_index,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [VALUE_WIDTH-1:0] element,
	output logic                          is_last,
	output logic                          is_empty,
	output logic                          overflow,
	input  logic                          cfg_we,
	input  logic [3:0]                    cfg_wdata
);

	localparam int LW = $clog2(NUM_LISTS);
	localparam int PW = $clog2(LIST_CAPACITY);
	localparam int CW = $clog2(LIST_CAPACITY + 1);
	localparam int AW = LW + PW;

	slim_pkg::state_t st_q, st_d;

	logic [3:0]                    lu_q;
	logic [CW-1:0]                 cnt_q [NUM_LISTS];
	logic [LW-1:0]                 lst_q;
	logic [LW:0]                   src_q;
	logic [CW-1:0]                 pos_q;
	logic [CW-1:0]                 sidx_q;
	logic [CW-1:0]                 eidx_q;
	logic signed [VALUE_WIDTH-1:0] val_q;
	logic                          mrg_q;
	logic                          ovf_q;
	logic                          ovalid_q;
	logic signed [VALUE_WIDTH-1:0] elem_q;
	logic                          last_q;
	logic                          empty_q;
	logic                          oovf_q;

	logic                          mem_we;
	logic [AW-1:0]                 mem_waddr;
	logic [VALUE_WIDTH-1:0]        mem_wdata;
	logic [AW-1:0]                 mem_raddr;
	logic [VALUE_WIDTH-1:0]        mem_rdata;

	logic                          accept;
	logic                          in_ok;
	logic [LW-1:0]                 li;
	logic                          li_full;
	logic [LW-1:0]                 src_i;
	logic                          mrg_more;
	logic                          src_more;
	logic                          ge;
	logic                          full0;
	logic                          ins_done;
	logic                          out_free;
	logic [CW-1:0]                 n_lst;
	logic [CW-1:0]                 eidx_nxt;
	logic                          elast;

	// Handshake and decode helpers.
	assign accept   = in_valid && !in_stall;
	assign in_stall = (st_q != slim_pkg::ST_IDLE) || ovalid_q;
	assign in_ok    = 32'(list_index) < NUM_LISTS;
	assign li       = LW'(list_index);
	assign li_full  = 32'(cnt_q[li]) >= LIST_CAPACITY;
	assign src_i    = src_q[LW-1:0];
	assign mrg_more = (32'(src_q) < 32'(lu_q)) && (32'(src_q) < NUM_LISTS);
	assign src_more = sidx_q < cnt_q[src_i];
	assign ge       = $signed(mem_rdata) >= val_q;
	assign full0    = 32'(cnt_q[0]) >= LIST_CAPACITY;
	assign ins_done = ((st_q == slim_pkg::ST_INS_RD) && (pos_q == '0))
		|| ((st_q == slim_pkg::ST_INS_CMP) && !ge);
	assign out_free = !ovalid_q || !out_stall;
	assign n_lst    = cnt_q[lst_q];
	assign eidx_nxt = eidx_q + CW'(1);
	assign elast    = eidx_nxt == n_lst;

	// Next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			slim_pkg::ST_IDLE: begin
				if (accept) begin
					case (slim_pkg::op_t'(operation))
						slim_pkg::OP_INSERT: st_d = (in_ok && !li_full) ?
							slim_pkg::ST_INS_RD : slim_pkg::ST_IDLE;
						slim_pkg::OP_MERGE:  st_d = slim_pkg::ST_MRG_SEL;
						slim_pkg::OP_READ:   st_d = in_ok ?
							slim_pkg::ST_EMIT_RD : slim_pkg::ST_IDLE;
						default:             st_d = slim_pkg::ST_IDLE;
					endcase
				end
			end
			slim_pkg::ST_INS_RD: begin
				if (pos_q == '0) begin
					st_d = mrg_q ? slim_pkg::ST_MRG_SEL : slim_pkg::ST_IDLE;
				end else begin
					st_d = slim_pkg::ST_INS_CMP;
				end
			end
			slim_pkg::ST_INS_CMP: begin
				if (ge) begin
					st_d = slim_pkg::ST_INS_RD;
				end else begin
					st_d = mrg_q ? slim_pkg::ST_MRG_SEL : slim_pkg::ST_IDLE;
				end
			end
			slim_pkg::ST_MRG_SEL: begin
				if (!mrg_more) begin
					st_d = slim_pkg::ST_EMIT_RD;
				end else if (src_more) begin
					st_d = slim_pkg::ST_MRG_LD;
				end
			end
			slim_pkg::ST_MRG_LD: begin
				st_d = full0 ? slim_pkg::ST_MRG_SEL : slim_pkg::ST_INS_RD;
			end
			slim_pkg::ST_EMIT_RD: begin
				if (out_free) begin
					st_d = (n_lst == '0) ? slim_pkg::ST_IDLE : slim_pkg::ST_EMIT_LD;
				end
			end
			slim_pkg::ST_EMIT_LD: begin
				st_d = elast ? slim_pkg::ST_IDLE : slim_pkg::ST_EMIT_RD;
			end
			default: st_d = slim_pkg::ST_IDLE;
		endcase
	end

	// Memory port control.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = val_q;
		mem_raddr = '0;
		case (st_q)
			slim_pkg::ST_INS_RD: begin
				if (pos_q == '0) begin
					mem_we    = 1'b1;
					mem_waddr = {lst_q, PW'(0)};
				end else begin
					mem_raddr = {lst_q, PW'(pos_q - CW'(1))};
				end
			end
			slim_pkg::ST_INS_CMP: begin
				mem_we    = 1'b1;
				mem_waddr = {lst_q, pos_q[PW-1:0]};
				mem_wdata = ge ? mem_rdata : val_q;
			end
			slim_pkg::ST_MRG_SEL: mem_raddr = {src_i, sidx_q[PW-1:0]};
			slim_pkg::ST_EMIT_RD: mem_raddr = {lst_q, eidx_q[PW-1:0]};
			default: ;
		endcase
	end

	slim_mem #(
		.WIDTH(VALUE_WIDTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Sequencer registers, list counts and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= slim_pkg::ST_IDLE;
			lu_q     <= slim_pkg::LISTS_IN_USE_RESET;
			for (int i = 0; i < NUM_LISTS; i++) cnt_q[i] <= '0;
			lst_q    <= '0;
			src_q    <= '0;
			pos_q    <= '0;
			sidx_q   <= '0;
			eidx_q   <= '0;
			val_q    <= '0;
			mrg_q    <= 1'b0;
			ovf_q    <= 1'b0;
			ovalid_q <= 1'b0;
			elem_q   <= '0;
			last_q   <= 1'b0;
			empty_q  <= 1'b0;
			oovf_q   <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				lu_q <= cfg_wdata;
			end
			// A taken beat frees the output register; a load below overrides.
			if (ovalid_q && !out_stall) begin
				ovalid_q <= 1'b0;
			end
			case (st_q)
				slim_pkg::ST_IDLE: begin
					if (accept) begin
						case (slim_pkg::op_t'(operation))
							slim_pkg::OP_INSERT: begin
								mrg_q <= 1'b0;
								ovf_q <= 1'b0;
								if (in_ok && !li_full) begin
									lst_q <= li;
									val_q <= value;
									pos_q <= cnt_q[li];
								end else begin
									ovalid_q <= 1'b1;
									elem_q   <= '0;
									last_q   <= 1'b1;
									empty_q  <= 1'b0;
									oovf_q   <= in_ok;
								end
							end
							slim_pkg::OP_MERGE: begin
								mrg_q  <= 1'b1;
								ovf_q  <= 1'b0;
								src_q  <= (LW + 1)'(1);
								sidx_q <= '0;
							end
							slim_pkg::OP_READ: begin
								mrg_q  <= 1'b0;
								ovf_q  <= 1'b0;
								eidx_q <= '0;
								if (in_ok) begin
									lst_q <= li;
								end else begin
									ovalid_q <= 1'b1;
									elem_q   <= '0;
									last_q   <= 1'b1;
									empty_q  <= 1'b1;
									oovf_q   <= 1'b0;
								end
							end
							default: ;
						endcase
					end
				end
				slim_pkg::ST_INS_CMP: begin
					if (ge) begin
						pos_q <= pos_q - CW'(1);
					end
				end
				slim_pkg::ST_MRG_SEL: begin
					if (!mrg_more) begin
						lst_q  <= '0;
						eidx_q <= '0;
					end else if (!src_more) begin
						cnt_q[src_i] <= '0;
						src_q        <= src_q + (LW + 1)'(1);
						sidx_q       <= '0;
					end
				end
				slim_pkg::ST_MRG_LD: begin
					val_q <= $signed(mem_rdata);
					lst_q <= '0;
					if (full0) begin
						ovf_q  <= 1'b1;
						sidx_q <= sidx_q + CW'(1);
					end else begin
						pos_q <= cnt_q[0];
					end
				end
				slim_pkg::ST_EMIT_RD: begin
					if (out_free && (n_lst == '0)) begin
						ovalid_q <= 1'b1;
						elem_q   <= '0;
						last_q   <= 1'b1;
						empty_q  <= 1'b1;
						oovf_q   <= ovf_q;
					end
				end
				slim_pkg::ST_EMIT_LD: begin
					ovalid_q <= 1'b1;
					elem_q   <= $signed(mem_rdata);
					last_q   <= elast;
					empty_q  <= 1'b0;
					oovf_q   <= ovf_q;
					eidx_q   <= eidx_nxt;
				end
				default: ;
			endcase
			// End of an insert walk: bump the count, then acknowledge or resume the merge.
			if (ins_done) begin
				cnt_q[lst_q] <= n_lst + CW'(1);
				if (mrg_q) begin
					sidx_q <= sidx_q + CW'(1);
				end else begin
					ovalid_q <= 1'b1;
					elem_q   <= '0;
					last_q   <= 1'b1;
					empty_q  <= 1'b0;
					oovf_q   <= 1'b0;
				end
			end
		end
	end

	assign out_valid = ovalid_q;
	assign element   = elem_q;
	assign is_last   = last_q;
	assign is_empty  = empty_q;
	assign overflow  = oovf_q;

endmodule

// File: src/slim_mem.sv
// Single write port, single read port list store with a registered read.
// Standalone; instantiated by sorted_lists_insert_merge.
module slim_mem #(
	parameter int WIDTH = 16,
	parameter int AW    = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [2**AW];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
